// ----- rtl/core/xxh64_pkg.sv -----
package xxh64_pkg;

	localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] P3 = 64'h165667B19E3779F9;
	localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

	localparam int unsigned LANES = 4;
	localparam int unsigned STRIPE_BYTES = 32;
	localparam int unsigned BEAT_BYTES = 8;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} mul_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ABSORB,
		S_RND_A,
		S_RND_B,
		S_MRG_SUM,
		S_MRG_A,
		S_MRG_B,
		S_MRG_C,
		S_LEN,
		S_TAIL,
		S_T8_A,
		S_T8_B,
		S_T8_C,
		S_T4_A,
		S_T4_B,
		S_T1_A,
		S_T1_B,
		S_AV_A,
		S_AV_B,
		S_DONE
	} state_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
		rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
	endfunction

endpackage

// ----- rtl/core/xxh64_mul.sv -----
module xxh64_mul
	import xxh64_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	// 64x64 product modulo 2^64 from three 32x32 partial products, one a cycle
	logic [1:0]  phase_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] p_q;
	logic [31:0] x;
	logic [31:0] y;
	logic [63:0] prod;

	always_comb begin
		unique case (phase_q)
			2'd2: begin
				x = a_q[31:0];
				y = b_q[63:32];
			end
			2'd3: begin
				x = a_q[63:32];
				y = b_q[31:0];
			end
			default: begin
				x = a_q[31:0];
				y = b_q[31:0];
			end
		endcase
	end

	assign prod = {32'd0, x} * {32'd0, y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				2'd0: if (req.start) phase_q <= 2'd1;
				2'd1: phase_q <= 2'd2;
				2'd2: phase_q <= 2'd3;
				2'd3: begin
					phase_q <= 2'd0;
					done_q  <= 1'b1;
				end
				default: phase_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			2'd0: if (req.start) begin
				a_q <= req.a;
				b_q <= req.b;
			end
			2'd1: p_q <= prod;
			2'd2: p_q <= p_q + {prod[31:0], 32'd0};
			2'd3: p_q <= p_q + {prod[31:0], 32'd0};
			default: p_q <= p_q;
		endcase
	end

	assign rsp.done   = done_q;
	assign rsp.result = p_q;

endmodule

// ----- rtl/core/xxhash64_stream_digest.sv -----
// Streaming XXH64 (seed 0). The valid bytes of a beat are absorbed into the stripe one at a time;
// a beat that fills the 32-byte stripe adds 8 multiplies.
// The last beat adds finalization: up to 12 multiplies for the merge, up to 17 for the
// tail and 2 for the avalanche, all on one shared 64x64 multiplier built from three
// 32x32 partial products. One beat is in work at a time.
// Reset (arst_n, async) restores seed-zero lanes, zero length and an empty stripe.
module xxhash64_stream_digest
	import xxh64_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [63:0] digest
);

	state_t      st_q;
	state_t      st_nxt;
	mul_req_t    mreq;
	mul_rsp_t    mrsp;
	logic        mul_use;
	logic        pend_q;
	logic [63:0] acc_q [LANES];
	logic [1:0]  lane_q;
	logic [63:0] len_q;
	logic [4:0]  fill_q;
	logic [STRIPE_BYTES*8-1:0] buf_q;
	logic [63:0] data_q;
	logic [3:0]  bcnt_q;
	logic        last_q;
	logic [63:0] h_q;
	logic [63:0] t_q;
	logic [63:0] out_q;
	logic        out_vld_q;
	logic        out_free;
	logic [3:0]  cnt_sat;
	logic [63:0] res;
	logic [63:0] lane_word;

	assign cnt_sat   = (byte_count > 4'(BEAT_BYTES)) ? 4'(BEAT_BYTES) : byte_count;
	assign res       = mrsp.result;
	assign lane_word = buf_q[{lane_q, 6'd0} +: 64];
	assign out_free  = !out_vld_q || !digest_stall;

	xxh64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			S_IDLE:    if (data_valid) st_nxt = S_ABSORB;
			S_ABSORB: begin
				if (bcnt_q == 4'd0) st_nxt = last_q ? S_MRG_SUM : S_IDLE;
				else if (fill_q == 5'(STRIPE_BYTES - 1)) st_nxt = S_RND_A;
			end
			S_RND_A:   if (mrsp.done) st_nxt = S_RND_B;
			S_RND_B:   if (mrsp.done) st_nxt = (lane_q == 2'd3) ? S_ABSORB : S_RND_A;
			S_MRG_SUM: st_nxt = (len_q >= 64'(STRIPE_BYTES)) ? S_MRG_A : S_LEN;
			S_MRG_A:   if (mrsp.done) st_nxt = S_MRG_B;
			S_MRG_B:   if (mrsp.done) st_nxt = S_MRG_C;
			S_MRG_C:   if (mrsp.done) st_nxt = (lane_q == 2'd3) ? S_LEN : S_MRG_A;
			S_LEN:     st_nxt = S_TAIL;
			S_TAIL: begin
				priority if (fill_q >= 5'd8) st_nxt = S_T8_A;
				else if (fill_q >= 5'd4) st_nxt = S_T4_A;
				else if (fill_q != 5'd0) st_nxt = S_T1_A;
				else st_nxt = S_AV_A;
			end
			S_T8_A:    if (mrsp.done) st_nxt = S_T8_B;
			S_T8_B:    if (mrsp.done) st_nxt = S_T8_C;
			S_T8_C:    if (mrsp.done) st_nxt = S_TAIL;
			S_T4_A:    if (mrsp.done) st_nxt = S_T4_B;
			S_T4_B:    if (mrsp.done) st_nxt = S_TAIL;
			S_T1_A:    if (mrsp.done) st_nxt = S_T1_B;
			S_T1_B:    if (mrsp.done) st_nxt = S_TAIL;
			S_AV_A:    if (mrsp.done) st_nxt = S_AV_B;
			S_AV_B:    if (mrsp.done) st_nxt = S_DONE;
			S_DONE:    if (out_free) st_nxt = S_IDLE;
			default:   st_nxt = S_IDLE;
		endcase
	end

	// multiplier operands per step
	always_comb begin
		mul_use = 1'b1;
		mreq.a  = t_q;
		mreq.b  = P1;
		unique case (st_q)
			S_RND_A: begin mreq.a = lane_word;               mreq.b = P2; end
			S_RND_B: begin mreq.a = t_q;                     mreq.b = P1; end
			S_MRG_A: begin mreq.a = acc_q[lane_q];           mreq.b = P2; end
			S_MRG_B: begin mreq.a = t_q;                     mreq.b = P1; end
			S_MRG_C: begin mreq.a = h_q;                     mreq.b = P1; end
			S_T8_A:  begin mreq.a = buf_q[63:0];             mreq.b = P2; end
			S_T8_B:  begin mreq.a = t_q;                     mreq.b = P1; end
			S_T8_C:  begin mreq.a = rotl(h_q, 6'd27);        mreq.b = P1; end
			S_T4_A:  begin mreq.a = {32'd0, buf_q[31:0]};    mreq.b = P1; end
			S_T4_B:  begin mreq.a = rotl(h_q, 6'd23);        mreq.b = P2; end
			S_T1_A:  begin mreq.a = {56'd0, buf_q[7:0]};     mreq.b = P5; end
			S_T1_B:  begin mreq.a = rotl(h_q, 6'd11);        mreq.b = P1; end
			S_AV_A:  begin mreq.a = h_q ^ (h_q >> 33);       mreq.b = P2; end
			S_AV_B:  begin mreq.a = h_q ^ (h_q >> 29);       mreq.b = P3; end
			default: mul_use = 1'b0;
		endcase
		mreq.start = mul_use && !pend_q;
	end

	assign data_stall   = (st_q != S_IDLE);
	assign digest_valid = out_vld_q;
	assign digest       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
			lane_q    <= 2'd0;
			fill_q    <= 5'd0;
			bcnt_q    <= 4'd0;
			last_q    <= 1'b0;
			len_q     <= 64'd0;
			acc_q[0]  <= P1 + P2;
			acc_q[1]  <= P2;
			acc_q[2]  <= 64'd0;
			acc_q[3]  <= 64'd0 - P1;
		end else begin
			st_q <= st_nxt;
			if (mreq.start) pend_q <= 1'b1;
			else if (mrsp.done) pend_q <= 1'b0;
			if (st_q == S_DONE && out_free) out_vld_q <= 1'b1;
			else if (!digest_stall) out_vld_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (data_valid) begin
					bcnt_q <= cnt_sat;
					last_q <= last;
					len_q  <= len_q + {60'd0, cnt_sat};
				end
				S_ABSORB: if (bcnt_q != 4'd0) begin
					bcnt_q <= bcnt_q - 4'd1;
					fill_q <= fill_q + 5'd1;
				end
				S_RND_B: if (mrsp.done) begin
					acc_q[lane_q] <= res;
					lane_q        <= lane_q + 2'd1;
				end
				S_MRG_C: if (mrsp.done) lane_q <= lane_q + 2'd1;
				S_T8_C:  if (mrsp.done) fill_q <= fill_q - 5'd8;
				S_T4_B:  if (mrsp.done) fill_q <= fill_q - 5'd4;
				S_T1_B:  if (mrsp.done) fill_q <= fill_q - 5'd1;
				S_DONE: if (out_free) begin
					len_q    <= 64'd0;
					acc_q[0] <= P1 + P2;
					acc_q[1] <= P2;
					acc_q[2] <= 64'd0;
					acc_q[3] <= 64'd0 - P1;
				end
				default: ;
			endcase
		end
	end

	// payload: beat word, stripe bytes, running hash
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE:  if (data_valid) data_q <= data_word;
			S_ABSORB: if (bcnt_q != 4'd0) begin
				buf_q[{fill_q, 3'd0} +: 8] <= data_q[7:0];
				data_q                     <= data_q >> 8;
			end
			S_RND_A: if (mrsp.done) t_q <= rotl(acc_q[lane_q] + res, 6'd31);
			S_MRG_SUM: begin
				if (len_q >= 64'(STRIPE_BYTES))
					h_q <= rotl(acc_q[0], 6'd1) + rotl(acc_q[1], 6'd7)
						+ rotl(acc_q[2], 6'd12) + rotl(acc_q[3], 6'd18);
				else
					h_q <= P5;
			end
			S_MRG_A: if (mrsp.done) t_q <= rotl(res, 6'd31);
			S_MRG_B: if (mrsp.done) h_q <= h_q ^ res;
			S_MRG_C: if (mrsp.done) h_q <= res + P4;
			S_LEN:   h_q <= h_q + len_q;
			S_T8_A:  if (mrsp.done) t_q <= rotl(res, 6'd31);
			S_T8_B:  if (mrsp.done) h_q <= h_q ^ res;
			S_T8_C: if (mrsp.done) begin
				h_q   <= res + P4;
				buf_q <= buf_q >> 64;
			end
			S_T4_A:  if (mrsp.done) h_q <= h_q ^ res;
			S_T4_B: if (mrsp.done) begin
				h_q   <= res + P3;
				buf_q <= buf_q >> 32;
			end
			S_T1_A:  if (mrsp.done) h_q <= h_q ^ res;
			S_T1_B: if (mrsp.done) begin
				h_q   <= res;
				buf_q <= buf_q >> 8;
			end
			S_AV_A:  if (mrsp.done) h_q <= res;
			S_AV_B:  if (mrsp.done) h_q <= res;
			S_DONE:  if (out_free) out_q <= h_q ^ (h_q >> 32);
			default: ;
		endcase
	end

	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> pend_q)
		else $error("multiplier finished without a request");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done && !mreq.start |=> !pend_q)
		else $error("pending flag stuck after multiplier result");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && !data_stall && last |=> st_q != S_IDLE)
		else $error("last beat did not start finalization");

	a_out_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		!digest_valid ##1 digest_valid |-> $past(st_q) == S_DONE)
		else $error("digest raised outside final step");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import xxh64_pkg::*;

	localparam int unsigned IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        data_valid;
	logic        data_stall;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last;
	logic        digest_valid;
	logic        digest_stall;
	logic [63:0] digest;

	xxhash64_stream_digest i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_word    (data_word),
		.byte_count   (byte_count),
		.last         (last),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	// predictor state
	logic [63:0] lane_acc [4];
	logic [63:0] msg_len;
	logic [7:0]  stripe [32];
	int unsigned stripe_fill;

	logic [63:0] digest_queue [$];
	int unsigned error_count;
	int unsigned beats_sent;
	int unsigned digests_seen;
	int unsigned messages_sent;
	int unsigned idle_cycles;
	bit          no_idle;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] rot(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] mix_round(input logic [63:0] acc, input logic [63:0] lane);
		acc = acc + lane * P2;
		acc = rot(acc, 31);
		return acc * P1;
	endfunction

	function automatic logic [63:0] stripe_word(input int unsigned pos, input int unsigned n);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < n; i++)
			v |= 64'(stripe[pos + i]) << (8 * i);
		return v;
	endfunction

	task automatic start_message();
		lane_acc[0] = P1 + P2;
		lane_acc[1] = P2;
		lane_acc[2] = '0;
		lane_acc[3] = 64'd0 - P1;
		msg_len = '0;
		stripe_fill = 0;
	endtask

	function automatic logic [63:0] final_digest();
		logic [63:0] h;
		int unsigned pos;
		pos = 0;
		if (msg_len >= 64'd32) begin
			h = rot(lane_acc[0], 1) + rot(lane_acc[1], 7) + rot(lane_acc[2], 12)
				+ rot(lane_acc[3], 18);
			for (int i = 0; i < 4; i++) begin
				h ^= mix_round(64'd0, lane_acc[i]);
				h = h * P1 + P4;
			end
		end else begin
			h = P5;
		end
		h += msg_len;
		while (pos + 8 <= stripe_fill) begin
			h ^= mix_round(64'd0, stripe_word(pos, 8));
			h = rot(h, 27) * P1 + P4;
			pos += 8;
		end
		if (pos + 4 <= stripe_fill) begin
			h ^= stripe_word(pos, 4) * P1;
			h = rot(h, 23) * P2 + P3;
			pos += 4;
		end
		while (pos < stripe_fill) begin
			h ^= 64'(stripe[pos]) * P5;
			h = rot(h, 11) * P1;
			pos++;
		end
		h ^= h >> 33;
		h *= P2;
		h ^= h >> 29;
		h *= P3;
		h ^= h >> 32;
		return h;
	endfunction

	task automatic absorb_beat(input logic [63:0] w, input logic [3:0] cnt, input logic fin);
		int unsigned n;
		n = (cnt > 8) ? 8 : cnt;
		for (int i = 0; i < n; i++) begin
			stripe[stripe_fill] = w[8 * i +: 8];
			stripe_fill++;
			if (stripe_fill == 32) begin
				for (int l = 0; l < 4; l++)
					lane_acc[l] = mix_round(lane_acc[l], stripe_word(8 * l, 8));
				stripe_fill = 0;
			end
		end
		msg_len += 64'(n);
		if (fin) begin
			digest_queue.push_back(final_digest());
			start_message();
			messages_sent++;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic bit take_gap();
		return !no_idle && ($urandom_range(99) < 32);
	endfunction

	// hold valid after an accepted beat until the next beat or gap takes over
	task automatic send_beat(input logic [63:0] w, input logic [3:0] cnt, input logic fin);
		while (take_gap()) begin
			data_valid <= 1'b0;
			@(negedge clk);
		end
		data_valid <= 1'b1;
		data_word  <= w;
		byte_count <= cnt;
		last       <= fin;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		absorb_beat(w, cnt, fin);
		beats_sent++;
		@(negedge clk);
	endtask

	// stall the result side at random
	always @(negedge clk)
		digest_stall <= take_gap();

	always @(posedge clk) begin
		if (arst_n && digest_valid && !digest_stall) begin
			digests_seen++;
			if (digest_queue.size() == 0) begin
				report_mismatch("unexpected digest", digest, 64'd0);
			end else begin
				logic [63:0] want;
				want = digest_queue.pop_front();
				if (digest !== want)
					report_mismatch("digest", digest, want);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((data_valid && !data_stall) || (digest_valid && !digest_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_message(input int unsigned nbytes);
		int unsigned left;
		left = nbytes;
		while (left > 8) begin
			send_beat(rand64(), 4'd8, 1'b0);
			left -= 8;
		end
		send_beat(rand64(), 4'(left), 1'b1);
	endtask

	task automatic test_directed();
		send_beat(64'd0, 4'd0, 1'b1);                      // empty message
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
		send_beat(64'h0, 4'd8, 1'b1);
		send_beat(64'hA5A5_5A5A_0123_4567, 4'd4, 1'b1);
		send_beat(64'h1122_3344_5566_7788, 4'd15, 1'b1);   // count saturates
		send_beat(64'hDEAD_BEEF_CAFE_F00D, 4'd9, 1'b0);
		send_beat(64'h0, 4'd0, 1'b0);                      // empty beat, ignored
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
		send_beat(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
		send_beat(64'hFEDC_BA98_7654_3210, 4'd8, 1'b0);
		send_beat(64'h0, 4'd0, 1'b1);                      // 32 bytes, empty last
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0);
		for (int i = 0; i < 5; i++)
			send_beat(64'h8000_0000_0000_0001, 4'd7, 1'b0);
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd5, 1'b1);    // 43 bytes, 8-byte and single-byte tail steps
	endtask

	task automatic test_random_messages(input int unsigned target);
		while (beats_sent < target) begin
			if ($urandom_range(99) < 85) begin
				send_message($urandom_range(99) < 80 ? $urandom_range(0, 40)
					: $urandom_range(41, 140));
			end else begin
				// odd beat shapes: partial words, oversized counts, empty beats
				logic [3:0] c;
				c = 4'($urandom_range(15));
				send_beat(rand64(), c, (c != 0) ? ($urandom_range(3) == 0)
					: 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		data_valid   = 1'b0;
		data_word    = '0;
		byte_count   = '0;
		last         = 1'b0;
		digest_stall = 1'b0;
		no_idle      = 1'b0;
		error_count  = 0;
		beats_sent   = 0;
		digests_seen = 0;
		messages_sent = 0;
		idle_cycles  = 0;
		start_message();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_messages(1000);
		no_idle = 1'b1;
		test_random_messages(1300);
		no_idle = 1'b0;
		test_random_messages(1750);
		data_valid <= 1'b0;

		while (digest_queue.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("sent %0d beats in %0d messages, checked %0d digests",
			beats_sent, messages_sent, digests_seen);
		if (error_count == 0 && digest_queue.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
